// ----- hw/rtl/gwns_pkg.sv -----
// Shared types and constants for the grid wavefront next-step block.
`default_nettype none
package gwns_pkg;

  typedef logic [2:0] dir_t;

  localparam dir_t DIR_NONE  = 3'd0;
  localparam dir_t DIR_UP    = 3'd1;
  localparam dir_t DIR_RIGHT = 3'd2;
  localparam dir_t DIR_DOWN  = 3'd3;
  localparam dir_t DIR_LEFT  = 3'd4;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [3:0] {
    ST_RCLR,
    ST_IDLE,
    ST_QCLR,
    ST_SEED,
    ST_POP_RD,
    ST_POP,
    ST_NB_RD,
    ST_NB_WR,
    ST_FIN_RD,
    ST_FIN_S,
    ST_FIN_NB,
    ST_FIN_CK,
    ST_OUT
  } state_t;

endpackage
`default_nettype wire

// ----- hw/rtl/grid_wavefront_next_step.sv -----
// Grid wavefront next-step: obstacle map, breadth-first search and first-step pick.
// A query first clears the distance map, then runs the search outward from the target,
// which walks a queue memory one read port at a time, and then picks the step.
// The result strobe done lasts one cycle; the receiver cannot stall it.
// After reset the block sweeps the obstacle map open with busy high.
`default_nettype none
module grid_wavefront_next_step #(
  parameter int GRID_ROWS = 32,
  parameter int GRID_COLS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              kind,
  input  logic [4:0]        row,
  input  logic [4:0]        col,
  input  logic              is_rock,
  input  logic [4:0]        target_row,
  input  logic [4:0]        target_col,
  output logic              done,
  output gwns_pkg::dir_t    direction
);
  import gwns_pkg::*;

  localparam int RW    = (GRID_ROWS > 2) ? $clog2(GRID_ROWS) : 1;
  localparam int CW    = (GRID_COLS > 2) ? $clog2(GRID_COLS) : 1;
  localparam int CELLS = GRID_ROWS * GRID_COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int QW    = RW + CW + AW;

  typedef logic [RW-1:0] r_t;
  typedef logic [CW-1:0] c_t;
  typedef logic [AW-1:0] a_t;

  function automatic a_t addr_of(input r_t r, input c_t c);
    addr_of = AW'(r) * AW'(GRID_COLS) + AW'(c);
  endfunction

  // Memories.
  logic            rock_mem [CELLS];
  logic [AW:0]     dist_mem [CELLS];
  logic [QW-1:0]   q_mem    [CELLS];
  logic            rock_rd;
  logic [AW:0]     dist_rd;
  logic [QW-1:0]   q_rd;

  logic            rock_we, dist_we, q_we;
  a_t              rock_wa, dist_wa, rock_ra, dist_ra, q_wa, q_ra;
  logic            rock_wd;
  logic [AW:0]     dist_wd;
  logic [QW-1:0]   q_wd;

  always_ff @(posedge clk) begin
    if (rock_we) rock_mem[rock_wa] <= rock_wd;
    rock_rd <= rock_mem[rock_ra];
  end

  always_ff @(posedge clk) begin
    if (dist_we) dist_mem[dist_wa] <= dist_wd;
    dist_rd <= dist_mem[dist_ra];
  end

  always_ff @(posedge clk) begin
    if (q_we) q_mem[q_wa] <= q_wd;
    q_rd <= q_mem[q_ra];
  end

  // Registers.
  state_t      state, state_next;
  a_t          clr_addr, clr_addr_next;
  r_t          st_r, st_r_next, tg_r, tg_r_next, cur_r, cur_r_next, nb_r, nb_r_next;
  c_t          st_c, st_c_next, tg_c, tg_c_next, cur_c, cur_c_next, nb_c, nb_c_next;
  a_t          cur_d, cur_d_next, s_d, s_d_next;
  logic [AW:0] head, head_next, tail, tail_next;
  logic [1:0]  nb, nb_next;
  dir_t        res_dir, res_dir_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_RCLR;
      clr_addr <= '0;
      head     <= '0;
      tail     <= '0;
      nb       <= '0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      head     <= head_next;
      tail     <= tail_next;
      nb       <= nb_next;
    end
  end

  always_ff @(posedge clk) begin
    st_r    <= st_r_next;
    st_c    <= st_c_next;
    tg_r    <= tg_r_next;
    tg_c    <= tg_c_next;
    cur_r   <= cur_r_next;
    cur_c   <= cur_c_next;
    cur_d   <= cur_d_next;
    nb_r    <= nb_r_next;
    nb_c    <= nb_c_next;
    s_d     <= s_d_next;
    res_dir <= res_dir_next;
  end

  // Neighbor of the current cell selected by nb, in the order up, right, down, left.
  logic [RW:0] n_rw;
  logic [CW:0] n_cw;
  logic        n_ok;
  always_comb begin
    n_rw = {1'b0, cur_r};
    n_cw = {1'b0, cur_c};
    n_ok = 1'b0;
    case (nb)
      2'd0: begin
        n_rw = {1'b0, cur_r} - 1'b1;
        n_ok = (cur_r != '0);
      end
      2'd1: begin
        n_cw = {1'b0, cur_c} + 1'b1;
        n_ok = (n_cw < (CW+1)'(GRID_COLS));
      end
      2'd2: begin
        n_rw = {1'b0, cur_r} + 1'b1;
        n_ok = (n_rw < (RW+1)'(GRID_ROWS));
      end
      default: begin
        n_cw = {1'b0, cur_c} - 1'b1;
        n_ok = (cur_c != '0);
      end
    endcase
  end

  logic in_row_ok, in_col_ok, tg_row_ok, tg_col_ok;
  assign in_row_ok = (32'(row) < 32'(GRID_ROWS));
  assign in_col_ok = (32'(col) < 32'(GRID_COLS));
  assign tg_row_ok = (32'(target_row) < 32'(GRID_ROWS));
  assign tg_col_ok = (32'(target_col) < 32'(GRID_COLS));

  always_comb begin
    state_next    = state;
    clr_addr_next = clr_addr;
    head_next     = head;
    tail_next     = tail;
    nb_next       = nb;
    st_r_next     = st_r;
    st_c_next     = st_c;
    tg_r_next     = tg_r;
    tg_c_next     = tg_c;
    cur_r_next    = cur_r;
    cur_c_next    = cur_c;
    cur_d_next    = cur_d;
    nb_r_next     = nb_r;
    nb_c_next     = nb_c;
    s_d_next      = s_d;
    res_dir_next  = res_dir;
    rock_we = 1'b0;
    rock_wa = clr_addr;
    rock_wd = 1'b0;
    rock_ra = addr_of(r_t'(n_rw), c_t'(n_cw));
    dist_we = 1'b0;
    dist_wa = clr_addr;
    dist_wd = '0;
    dist_ra = addr_of(r_t'(n_rw), c_t'(n_cw));
    q_we    = 1'b0;
    q_wa    = tail[AW-1:0];
    q_wd    = '0;
    q_ra    = head[AW-1:0];
    unique case (state)
      ST_RCLR: begin
        rock_we = 1'b1;
        clr_addr_next = clr_addr + 1'b1;
        if (32'(clr_addr) == CELLS - 1) begin
          clr_addr_next = '0;
          state_next    = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          if (kind == KIND_LOAD) begin
            rock_we = in_row_ok && in_col_ok;
            rock_wa = addr_of(r_t'(row), c_t'(col));
            rock_wd = is_rock;
          end else begin
            st_r_next = r_t'(row);
            st_c_next = c_t'(col);
            tg_r_next = r_t'(target_row);
            tg_c_next = c_t'(target_col);
            if (!(in_row_ok && in_col_ok && tg_row_ok && tg_col_ok)) begin
              res_dir_next = DIR_NONE;
              state_next   = ST_OUT;
            end else if (row == target_row && col == target_col) begin
              res_dir_next = DIR_RIGHT;
              state_next   = ST_OUT;
            end else begin
              clr_addr_next = '0;
              state_next    = ST_QCLR;
            end
          end
        end
      end
      ST_QCLR: begin
        dist_we = 1'b1;
        clr_addr_next = clr_addr + 1'b1;
        if (32'(clr_addr) == CELLS - 1) begin
          clr_addr_next = '0;
          state_next    = ST_SEED;
        end
      end
      ST_SEED: begin
        dist_we    = 1'b1;
        dist_wa    = addr_of(tg_r, tg_c);
        dist_wd    = {1'b1, {AW{1'b0}}};
        q_we       = 1'b1;
        q_wa       = '0;
        q_wd       = {tg_r, tg_c, {AW{1'b0}}};
        head_next  = '0;
        tail_next  = (AW+1)'(1);
        state_next = ST_POP_RD;
      end
      ST_POP_RD: begin
        if (head == tail) begin
          cur_r_next = st_r;
          cur_c_next = st_c;
          state_next = ST_FIN_RD;
        end else begin
          state_next = ST_POP;
        end
      end
      ST_POP: begin
        {cur_r_next, cur_c_next, cur_d_next} = q_rd;
        head_next  = head + 1'b1;
        nb_next    = '0;
        state_next = ST_NB_RD;
      end
      ST_NB_RD: begin
        if (n_ok) begin
          nb_r_next  = r_t'(n_rw);
          nb_c_next  = c_t'(n_cw);
          state_next = ST_NB_WR;
        end else if (nb == 2'd3) begin
          state_next = ST_POP_RD;
        end else begin
          nb_next = nb + 1'b1;
        end
      end
      ST_NB_WR: begin
        // An open cell not yet reached joins the wavefront one step further out.
        if (!rock_rd && !dist_rd[AW]) begin
          dist_we   = 1'b1;
          dist_wa   = addr_of(nb_r, nb_c);
          dist_wd   = {1'b1, cur_d + 1'b1};
          q_we      = 1'b1;
          q_wd      = {nb_r, nb_c, cur_d + 1'b1};
          tail_next = tail + 1'b1;
        end
        if (nb == 2'd3) begin
          state_next = ST_POP_RD;
        end else begin
          nb_next    = nb + 1'b1;
          state_next = ST_NB_RD;
        end
      end
      ST_FIN_RD: begin
        dist_ra    = addr_of(st_r, st_c);
        state_next = ST_FIN_S;
      end
      ST_FIN_S: begin
        if (!dist_rd[AW]) begin
          res_dir_next = DIR_NONE;
          state_next   = ST_OUT;
        end else begin
          s_d_next   = dist_rd[AW-1:0];
          nb_next    = '0;
          state_next = ST_FIN_NB;
        end
      end
      ST_FIN_NB: begin
        if (n_ok) begin
          state_next = ST_FIN_CK;
        end else if (nb == 2'd3) begin
          res_dir_next = DIR_NONE;
          state_next   = ST_OUT;
        end else begin
          nb_next = nb + 1'b1;
        end
      end
      ST_FIN_CK: begin
        // The first neighbor one round closer to the target gives the step.
        if (dist_rd[AW] && (dist_rd[AW-1:0] + 1'b1 == s_d)) begin
          res_dir_next = dir_t'({1'b0, nb} + 3'd1);
          state_next   = ST_OUT;
        end else if (nb == 2'd3) begin
          res_dir_next = DIR_NONE;
          state_next   = ST_OUT;
        end else begin
          nb_next    = nb + 1'b1;
          state_next = ST_FIN_NB;
        end
      end
      ST_OUT: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy      = (state != ST_IDLE);
  assign done      = (state == ST_OUT);
  assign direction = res_dir;

endmodule
`default_nettype wire

// ----- tb/sv/tb_grid_wavefront_next_step.sv -----
// Testbench for the grid wavefront next-step block: maze loads, path queries, scoreboard.
`timescale 1ns / 100ps
`default_nettype none
module tb_grid_wavefront_next_step;
  import gwns_pkg::*;

  localparam int ROWS = 32;
  localparam int COLS = 32;
  localparam int NCELL = ROWS * COLS;
  localparam longint CYCLE_LIMIT = 40_000_000;

  class route_scoreboard;
    bit   rock[NCELL];
    dir_t pending_dirs[$];
    int   errors;
    int   loads;
    int   queries;
    int   dir_seen[5];

    // Synchronous rounds grow out from the target until the start is marked
    // or a round marks nothing.
    function dir_t first_step(int sr, int sc, int tr, int tc);
      dir_t cur[NCELL];
      dir_t prv[NCELL];
      dir_t d;
      bit   grew;
      int   k;
      foreach (cur[i]) begin
        cur[i] = DIR_NONE;
        prv[i] = DIR_NONE;
      end
      cur[tr * COLS + tc] = DIR_RIGHT;
      prv[tr * COLS + tc] = DIR_RIGHT;
      grew = 1'b1;
      while (cur[sr * COLS + sc] == DIR_NONE && grew) begin
        grew = 1'b0;
        for (int r = 0; r < ROWS; r++) begin
          for (int c = 0; c < COLS; c++) begin
            k = r * COLS + c;
            if (cur[k] != DIR_NONE || rock[k]) continue;
            d = DIR_NONE;
            if (r > 0 && prv[k - COLS] != DIR_NONE) d = DIR_UP;
            else if (c + 1 < COLS && prv[k + 1] != DIR_NONE) d = DIR_RIGHT;
            else if (r + 1 < ROWS && prv[k + COLS] != DIR_NONE) d = DIR_DOWN;
            else if (c > 0 && prv[k - 1] != DIR_NONE) d = DIR_LEFT;
            if (d != DIR_NONE) begin
              cur[k] = d;
              grew = 1'b1;
            end
          end
        end
        prv = cur;
      end
      return cur[sr * COLS + sc];
    endfunction

    function void note_transaction(logic knd, int r, int c, logic rk, int tr, int tc);
      if (knd == KIND_LOAD) begin
        rock[r * COLS + c] = rk;
        loads++;
      end else begin
        pending_dirs.push_back(first_step(r, c, tr, tc));
        queries++;
      end
    endfunction

    task report(string msg);
      $display("%0t: mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(dir_t got);
      dir_t want;
      if (pending_dirs.size() == 0) begin
        report($sformatf("direction %0d with no query outstanding", got));
        return;
      end
      want = pending_dirs.pop_front();
      if (got <= DIR_LEFT) dir_seen[got]++;
      if (got !== want) report($sformatf("direction %0d, expected %0d", got, want));
    endtask
  endclass

  logic clk, rst, start, busy, kind, is_rock, done;
  logic [4:0] row, col, target_row, target_col;
  dir_t direction;
  route_scoreboard sb;
  longint cycles = 0;
  int idle_pct;

  grid_wavefront_next_step DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind), .row(row),
    .col(col), .is_rock(is_rock), .target_row(target_row), .target_col(target_col),
    .done(done), .direction(direction)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL grid_wavefront_next_step");
      $finish;
    end
    if (!rst) begin
      if (start && !busy)
        sb.note_transaction(kind, int'(row), int'(col), is_rock, int'(target_row),
                            int'(target_col));
      if (done) sb.check_result(direction);
    end
  end

  // Drives one transaction and holds it until accepted; start stays high on return.
  task send(logic knd, int r, int c, logic rk, int tr, int tc);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    kind <= knd;
    row <= 5'(r);
    col <= 5'(c);
    is_rock <= rk;
    target_row <= 5'(tr);
    target_col <= 5'(tc);
    do @(posedge clk); while (busy);
  endtask

  task load(int r, int c, logic rk);
    send(KIND_LOAD, r, c, rk, $urandom_range(31), $urandom_range(31));
  endtask

  task query(int r, int c, int tr, int tc);
    send(KIND_QUERY, r, c, 1'($urandom_range(1)), tr, tc);
  endtask

  task drain;
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending_dirs.size() != 0) @(posedge clk);
  endtask

  task random_phase(int n);
    repeat (n) begin
      if ($urandom_range(99) < 80) load($urandom_range(31), $urandom_range(31),
                                         $urandom_range(99) < 35);
      else query($urandom_range(31), $urandom_range(31),
                 $urandom_range(31), $urandom_range(31));
    end
  endtask

  initial begin
    sb = new();
    idle_pct = 0;
    start = 1'b0;
    kind = KIND_LOAD;
    row = '0;
    col = '0;
    is_rock = 1'b0;
    target_row = '0;
    target_col = '0;
    rst = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Open grid: each of the four steps, plus far corners.
    query(0, 0, 0, 5);
    query(5, 0, 0, 0);
    query(0, 0, 5, 0);
    query(0, 5, 0, 0);
    query(0, 0, 31, 31);
    query(31, 31, 0, 0);
    // Wall in one cell, then hit rock start, rock target and start equal to target.
    load(9, 10, 1'b1);
    load(11, 10, 1'b1);
    load(10, 9, 1'b1);
    load(10, 11, 1'b1);
    load(31, 31, 1'b1);
    load(0, 0, 1'b0);
    query(10, 10, 0, 0);
    query(0, 0, 10, 10);
    query(9, 10, 20, 20);
    query(20, 20, 9, 10);
    query(9, 10, 9, 10);
    query(31, 31, 31, 31);
    query(30, 31, 31, 31);
    query(7, 7, 7, 7);
    drain();

    random_phase(145);
    idle_pct = 64;
    random_phase(145);
    // Let every outstanding query finish before moving on.
    drain();
    idle_pct = 7;
    random_phase(145);
    idle_pct = 0;
    random_phase(125);
    drain();
    repeat (64) @(posedge clk);

    $display("covered %0d loads and %0d queries under varied sender gaps",
             sb.loads, sb.queries);
    $display("results none/up/right/down/left: %0d/%0d/%0d/%0d/%0d", sb.dir_seen[0],
             sb.dir_seen[1], sb.dir_seen[2], sb.dir_seen[3], sb.dir_seen[4]);
    if (sb.errors == 0 && sb.pending_dirs.size() == 0) begin
      $display("PASS grid_wavefront_next_step");
    end else begin
      $display("FAIL grid_wavefront_next_step");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- sim.f -----
hw/rtl/gwns_pkg.sv
hw/rtl/grid_wavefront_next_step.sv
tb/sv/tb_grid_wavefront_next_step.sv
